@@ sv/dsm_pkg.sv @@
// Shared types, codes and constants for the expression stack machine.
package dsm_pkg;

  localparam int DATA_W      = 64;
  localparam int HALF_W      = 32;
  localparam int OP_W        = 5;
  localparam int RC_W        = 4;
  localparam int LIMIT_W     = 6;
  localparam int CNT_OUT_W   = 6;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 5'd0,
    OP_DUP    = 5'd1,
    OP_DROP   = 5'd2,
    OP_SWAP   = 5'd3,
    OP_ROT    = 5'd4,
    OP_AND    = 5'd5,
    OP_MINUS  = 5'd6,
    OP_MUL    = 5'd7,
    OP_OR     = 5'd8,
    OP_PLUS   = 5'd9,
    OP_SHL    = 5'd10,
    OP_SHR    = 5'd11,
    OP_XOR    = 5'd12,
    OP_BRA    = 5'd13,
    OP_EQ     = 5'd14,
    OP_GE     = 5'd15,
    OP_GT     = 5'd16,
    OP_LE     = 5'd17,
    OP_LT     = 5'd18,
    OP_NE     = 5'd19,
    OP_RETURN = 5'd20,
    OP_CLEAR  = 5'd21
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_UNHANDLED = 2'd3
  } status_e;

  // whole-stack movement command
  typedef enum logic [2:0] {
    SC_HOLD,
    SC_PUSH,
    SC_POP,
    SC_SWAP,
    SC_ROT,
    SC_BINOP
  } stack_cmd_e;

  // per-cell source select
  typedef enum logic [1:0] {
    SEL_KEEP,
    SEL_PREV,
    SEL_NEXT,
    SEL_ALT
  } cell_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_RET
  } fsm_e;

  typedef enum logic [2:0] {
    MS_IDLE,
    MS_LL,
    MS_LH,
    MS_HL,
    MS_SUM
  } mul_step_e;

  // Cell 0 is the top of stack; alt feeds the ALU result to cell 0 and
  // the old top to cells 1 (swap) and 2 (rot).
  function automatic cell_sel_e cell_sel(stack_cmd_e cmd, int idx);
    cell_sel_e sel;
    sel = SEL_KEEP;
    case (cmd)
      SC_PUSH:  sel = SEL_PREV;
      SC_POP:   sel = SEL_NEXT;
      SC_SWAP:  sel = (idx == 0) ? SEL_NEXT : ((idx == 1) ? SEL_ALT : SEL_KEEP);
      SC_ROT:   sel = (idx <= 1) ? SEL_NEXT : ((idx == 2) ? SEL_ALT : SEL_KEEP);
      SC_BINOP: sel = (idx == 0) ? SEL_ALT : SEL_NEXT;
      default:  sel = SEL_KEEP;
    endcase
    return sel;
  endfunction

endpackage

@@ sv/dsm_cell.sv @@
// One stack cell: holds a value and takes it from a neighbor or a side input.
module dsm_cell (
  input  logic                       clk_i,
  input  dsm_pkg::cell_sel_e         sel_i,
  input  logic [dsm_pkg::DATA_W-1:0] prev_i,
  input  logic [dsm_pkg::DATA_W-1:0] next_i,
  input  logic [dsm_pkg::DATA_W-1:0] alt_i,
  output logic [dsm_pkg::DATA_W-1:0] value_o
);
  import dsm_pkg::*;

  logic [DATA_W-1:0] value_q, value_d;

  // source select
  always_comb begin
    case (sel_i)
      SEL_PREV: value_d = prev_i;
      SEL_NEXT: value_d = next_i;
      SEL_ALT:  value_d = alt_i;
      default:  value_d = value_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

@@ sv/dsm_mul.sv @@
// 64x64 wrapping multiply on one 32x32 multiplier: LL, LH, HL, sum.
module dsm_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dsm_pkg::DATA_W-1:0] a_i,
  input  logic [dsm_pkg::DATA_W-1:0] b_i,
  output logic                       done_o,
  output logic [dsm_pkg::DATA_W-1:0] product_o
);
  import dsm_pkg::*;

  mul_step_e         step_q, step_d;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [DATA_W-1:0] pp_q, acc_q;
  logic [DATA_W-1:0] pp_shift;

  // step sequencing
  always_comb begin
    case (step_q)
      MS_IDLE: step_d = start_i ? MS_LL : MS_IDLE;
      MS_LL:   step_d = MS_LH;
      MS_LH:   step_d = MS_HL;
      MS_HL:   step_d = MS_SUM;
      MS_SUM:  step_d = MS_IDLE;
      default: step_d = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= MS_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // operand select per step
  always_comb begin
    case (step_q)
      MS_LH: begin
        mul_a = a_i[HALF_W-1:0];
        mul_b = b_i[DATA_W-1:HALF_W];
      end
      MS_HL: begin
        mul_a = a_i[DATA_W-1:HALF_W];
        mul_b = b_i[HALF_W-1:0];
      end
      default: begin
        mul_a = a_i[HALF_W-1:0];
        mul_b = b_i[HALF_W-1:0];
      end
    endcase
  end

  // cross terms only count in the upper half
  assign pp_shift = {pp_q[HALF_W-1:0], {HALF_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    pp_q <= DATA_W'(mul_a) * DATA_W'(mul_b);
    case (step_q)
      MS_LH:   acc_q <= pp_q;
      MS_HL:   acc_q <= acc_q + pp_shift;
      default: acc_q <= acc_q;
    endcase
  end

  assign done_o    = (step_q == MS_SUM);
  assign product_o = acc_q + pp_shift;

endmodule

@@ sv/dwarf_expression_stack_machine_unit.sv @@
// Top level: expression stack machine built as a row of shifting stack cells.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+--------------------------------------
//  in       | input     | in_valid_i / in_ready_o | operation, push_value, return_count
//  out      | output    | out_valid_o/out_ready_i | status, result_value, value_valid,
//           |           |                         | branch_taken, stack_count, last
//  cfg      | input     | cfg_we_i                | cfg_wdata_i (depth limit)
//
//  The result is registered; in the idle state the next item is taken as soon as
//  the result register is empty or transfers in that cycle.
//  mul runs on the shared 32x32 multiplier and holds off input until it is done.
//  return emits one value per output transfer from the copy chain, then goes idle.
//  Reset empties the stack and sets the depth limit to 32; no clearing pass.
//  An output stall holds the result register and blocks further input transfers.
module dwarf_expression_stack_machine_unit #(
  parameter int NUM_CELLS   = 32,
  parameter int MAX_RETURNS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsm_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dsm_pkg::OP_W-1:0]      operation_i,
  input  logic [dsm_pkg::DATA_W-1:0]    push_value_i,
  input  logic [dsm_pkg::RC_W-1:0]      return_count_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [dsm_pkg::DATA_W-1:0]    result_value_o,
  output logic                          value_valid_o,
  output logic                          branch_taken_o,
  output logic [dsm_pkg::CNT_OUT_W-1:0] stack_count_o,
  output logic                          last_o
);
  import dsm_pkg::*;

  localparam int CW        = $clog2(NUM_CELLS + 1);
  localparam int CMPW      = (CW > 7) ? CW : 7;
  localparam int RET_LANES = (MAX_RETURNS < NUM_CELLS) ? MAX_RETURNS : NUM_CELLS;
  localparam int RLW       = $clog2(RET_LANES + 1);
  localparam int SHW       = $clog2(DATA_W);

  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(NUM_CELLS);
  localparam logic [CMPW-1:0] MAXR_C  = CMPW'(MAX_RETURNS);
  localparam logic [CMPW-1:0] TWO_C   = CMPW'(2);
  localparam logic [CMPW-1:0] THREE_C = CMPW'(3);

  // ---------------------------------------------------------------------
  // state
  fsm_e                  state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [LIMIT_W-1:0]    limit_q;
  logic [DATA_W-1:0]     ret_q [RET_LANES];
  logic [RLW-1:0]        left_q;

  logic                  out_valid_q, out_valid_d;
  status_e               o_status_q, o_status_d;
  logic [DATA_W-1:0]     o_value_q, o_value_d;
  logic                  o_vvalid_q, o_vvalid_d;
  logic                  o_taken_q, o_taken_d;
  logic [CNT_OUT_W-1:0]  o_count_q, o_count_d;
  logic                  o_last_q, o_last_d;
  logic                  out_load;

  logic [DATA_W-1:0]     cell_val [NUM_CELLS];
  stack_cmd_e            cmd_act;
  logic [DATA_W-1:0]     bin_res, alu_res, push_src, top_after;

  // decode results
  op_e                   op;
  stack_cmd_e            dec_cmd;
  logic [CW-1:0]         dec_cnt;
  status_e               dec_stat;
  logic                  dec_taken, dec_mul, dec_ret, dec_novalue;

  logic [CMPW-1:0]       n_ext, lim_ext, rc_ext, rc_sat;
  logic                  in_fire, out_free, empty, full;
  logic                  mul_done;
  logic [DATA_W-1:0]     mul_prod;

  assign op       = op_e'(operation_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire  = in_valid_i && in_ready_o;

  assign n_ext   = CMPW'(cnt_q);
  assign lim_ext = CMPW'(limit_q);
  assign rc_ext  = CMPW'(return_count_i);
  assign rc_sat  = (rc_ext > MAXR_C) ? MAXR_C : rc_ext;
  assign empty   = (cnt_q == '0);
  assign full    = (n_ext >= lim_ext) || (n_ext >= DEPTH_C);

  assign push_src = (op == OP_DUP) ? cell_val[0] : push_value_i;

  // ---------------------------------------------------------------------
  // ALU on the top two cells: second is left operand, top is right
  always_comb begin
    logic [DATA_W-1:0] a, b;
    logic              big_shift, s_eq, s_lt;
    a = cell_val[1];
    b = cell_val[0];
    big_shift = |b[DATA_W-1:SHW];
    s_eq = (a == b);
    s_lt = ($signed(a) < $signed(b));
    case (op)
      OP_AND:   alu_res = a & b;
      OP_MINUS: alu_res = a - b;
      OP_OR:    alu_res = a | b;
      OP_PLUS:  alu_res = a + b;
      OP_SHL:   alu_res = big_shift ? '0 : (a << b[SHW-1:0]);
      OP_SHR:   alu_res = big_shift ? '0 : (a >> b[SHW-1:0]);
      OP_XOR:   alu_res = a ^ b;
      OP_EQ:    alu_res = DATA_W'(s_eq);
      OP_GE:    alu_res = DATA_W'(!s_lt);
      OP_GT:    alu_res = DATA_W'(!s_lt && !s_eq);
      OP_LE:    alu_res = DATA_W'(s_lt || s_eq);
      OP_LT:    alu_res = DATA_W'(s_lt);
      OP_NE:    alu_res = DATA_W'(!s_eq);
      default:  alu_res = '0;
    endcase
  end

  assign bin_res = (state_q == ST_MUL) ? mul_prod : alu_res;

  // ---------------------------------------------------------------------
  // operation decode (used on an input transfer)
  always_comb begin
    dec_cmd     = SC_HOLD;
    dec_cnt     = cnt_q;
    dec_stat    = STAT_OK;
    dec_taken   = 1'b0;
    dec_mul     = 1'b0;
    dec_ret     = 1'b0;
    dec_novalue = 1'b0;
    case (op)
      OP_PUSH, OP_DUP: begin
        if (op == OP_DUP && empty) begin
          dec_stat = STAT_UNDERFLOW;
        end else if (full) begin
          dec_stat = STAT_OVERFLOW;
        end else begin
          dec_cmd = SC_PUSH;
          dec_cnt = cnt_q + CW'(1);
        end
      end
      OP_DROP, OP_BRA: begin
        if (empty) begin
          dec_stat = STAT_UNDERFLOW;
        end else begin
          dec_cmd   = SC_POP;
          dec_cnt   = cnt_q - CW'(1);
          dec_taken = (op == OP_BRA) && (cell_val[0] != '0);
        end
      end
      OP_SWAP: begin
        if (n_ext < TWO_C) dec_stat = STAT_UNDERFLOW;
        else dec_cmd = SC_SWAP;
      end
      OP_ROT: begin
        if (n_ext < THREE_C) dec_stat = STAT_UNDERFLOW;
        else dec_cmd = SC_ROT;
      end
      OP_MUL: begin
        if (n_ext < TWO_C) dec_stat = STAT_UNDERFLOW;
        else dec_mul = 1'b1;
      end
      OP_AND, OP_MINUS, OP_OR, OP_PLUS, OP_SHL, OP_SHR, OP_XOR,
      OP_EQ, OP_GE, OP_GT, OP_LE, OP_LT, OP_NE: begin
        if (n_ext < TWO_C) begin
          dec_stat = STAT_UNDERFLOW;
        end else begin
          dec_cmd = SC_BINOP;
          dec_cnt = cnt_q - CW'(1);
        end
      end
      OP_RETURN: begin
        if (rc_sat > n_ext) dec_stat = STAT_UNDERFLOW;
        else if (rc_sat == '0) dec_novalue = 1'b1;
        else dec_ret = 1'b1;
      end
      OP_CLEAR: dec_cnt = '0;
      default:  dec_stat = STAT_UNHANDLED;
    endcase
  end

  // ---------------------------------------------------------------------
  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && dec_mul) state_d = ST_MUL;
        else if (in_fire && dec_ret) state_d = ST_RET;
      end
      ST_MUL: if (mul_done) state_d = ST_IDLE;
      ST_RET: if (out_free && left_q == RLW'(1)) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // stack command, count update and result register load
  always_comb begin
    cmd_act    = SC_HOLD;
    cnt_d      = cnt_q;
    out_load   = 1'b0;
    o_status_d = STAT_OK;
    o_taken_d  = 1'b0;
    o_last_d   = 1'b1;
    top_after  = cell_val[0];
    o_vvalid_d = 1'b0;
    o_count_d  = CNT_OUT_W'(cnt_q);
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_act    = dec_cmd;
          cnt_d      = dec_cnt;
          out_load   = !dec_mul && !dec_ret;
          o_status_d = dec_stat;
          o_taken_d  = dec_taken;
          o_vvalid_d = (dec_cnt != '0) && !dec_novalue;
          o_count_d  = CNT_OUT_W'(dec_cnt);
          case (dec_cmd)
            SC_PUSH:  top_after = push_src;
            SC_POP,
            SC_SWAP,
            SC_ROT:   top_after = cell_val[1];
            SC_BINOP: top_after = bin_res;
            default:  top_after = cell_val[0];
          endcase
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          cmd_act    = SC_BINOP;
          cnt_d      = cnt_q - CW'(1);
          out_load   = 1'b1;
          top_after  = bin_res;
          o_vvalid_d = 1'b1;
          o_count_d  = CNT_OUT_W'(cnt_q - CW'(1));
        end
      end
      ST_RET: begin
        out_load   = out_free;
        top_after  = ret_q[0];
        o_vvalid_d = 1'b1;
        o_last_d   = (left_q == RLW'(1));
      end
      default: cmd_act = SC_HOLD;
    endcase
    o_value_d   = o_vvalid_d ? top_after : '0;
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  // ---------------------------------------------------------------------
  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (in_fire && dec_ret) begin
        left_q <= RLW'(rc_sat);
      end else if (state_q == ST_RET && out_free) begin
        left_q <= left_q - RLW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_status_q <= o_status_d;
      o_value_q  <= o_value_d;
      o_vvalid_q <= o_vvalid_d;
      o_taken_q  <= o_taken_d;
      o_count_q  <= o_count_d;
      o_last_q   <= o_last_d;
    end
  end

  // return copy chain: loaded from the top cells, shifts one value per transfer
  for (genvar r = 0; r < RET_LANES; r++) begin : g_ret
    always_ff @(posedge clk_i) begin
      if (in_fire && dec_ret) begin
        ret_q[r] <= cell_val[r];
      end else if (state_q == ST_RET && out_free) begin
        ret_q[r] <= (r < RET_LANES - 1) ? ret_q[(r < RET_LANES - 1) ? r + 1 : r] : '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // row of stack cells, cell 0 on top
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic [DATA_W-1:0] prev_v, next_v, alt_v;
    if (i == 0) begin : g_top
      assign prev_v = push_src;
      assign alt_v  = bin_res;
    end else begin : g_body
      assign prev_v = cell_val[i-1];
      if (i <= 2) begin : g_alt
        assign alt_v = cell_val[0];
      end else begin : g_noalt
        assign alt_v = '0;
      end
    end
    if (i < NUM_CELLS - 1) begin : g_next
      assign next_v = cell_val[i+1];
    end else begin : g_bottom
      assign next_v = '0;
    end

    dsm_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (cell_sel(cmd_act, i)),
      .prev_i  (prev_v),
      .next_i  (next_v),
      .alt_i   (alt_v),
      .value_o (cell_val[i])
    );
  end

  // multiplier on second (left) and top (right)
  dsm_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_fire && dec_mul),
    .a_i       (cell_val[1]),
    .b_i       (cell_val[0]),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = o_status_q;
  assign result_value_o = o_value_q;
  assign value_valid_o  = o_vvalid_q;
  assign branch_taken_o = o_taken_q;
  assign stack_count_o  = o_count_q;
  assign last_o         = o_last_q;

endmodule

@@ verif/dwarf_expression_stack_machine_unit_tb.sv @@
// Self-checking testbench for the expression stack machine: directed table, random ops, limit sweep.
`timescale 1ns / 1ps

module dwarf_expression_stack_machine_unit_tb;
  import dsm_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int NUM_CELLS    = 32;
  localparam int MAX_RETURNS  = 8;
  localparam int MAX_GAP      = 17;
  localparam int BURST_SPAN   = 32;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_GUARD   = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int N_DIRECTED   = 32;

  localparam logic [OP_W-1:0]    OP_FIRST_UNHANDLED = 5'd22;
  localparam logic [OP_W-1:0]    OP_LAST_UNHANDLED  = 5'd31;
  localparam logic [DATA_W-1:0]  ALL_ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0]  SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0]  MAX_POS  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [LIMIT_W-1:0] LIMIT_MIN  = 6'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_ZERO = 6'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX  = {LIMIT_W{1'b1}};

  typedef struct packed {
    status_e                status;
    logic [DATA_W-1:0]      value;
    logic                   vvalid;
    logic                   taken;
    logic [CNT_OUT_W-1:0]   cnt;
    logic                   last;
  } stack_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [DATA_W-1:0]  pv;
    logic [RC_W-1:0]    rc;
    logic               typed;
    stack_result_t      want;
  } drive_row_t;

  // DUT ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [OP_W-1:0]       operation_i = '0;
  logic [DATA_W-1:0]     push_value_i = '0;
  logic [RC_W-1:0]       return_count_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [1:0]            status_o;
  logic [DATA_W-1:0]     result_value_o;
  logic                  value_valid_o;
  logic                  branch_taken_o;
  logic [CNT_OUT_W-1:0]  stack_count_o;
  logic                  last_o;

  // shadow machine state
  logic [DATA_W-1:0]   stack_vals [NUM_CELLS];
  int                  stack_used;
  logic [LIMIT_W-1:0]  depth_limit_q;

  stack_result_t step_out[$];
  stack_result_t due_results[$];

  int  n_ops, n_results, n_errors;
  int  n_overflow, n_underflow, n_unhandled, n_taken;
  int  cycle_count;
  bit  send_burst, recv_burst;
  logic [LIMIT_W-1:0] mid_limit;

  // directed rows, starting from reset with limit 32 and an empty stack
  drive_row_t directed_rows [N_DIRECTED] = '{
    '{OP_DROP,   64'd0, 4'd0,  1'b1, '{STAT_UNDERFLOW, 64'd0, 1'b0, 1'b0, 6'd0, 1'b1}},
    '{OP_RETURN, 64'd0, 4'd0,  1'b1, '{STAT_OK, 64'd0, 1'b0, 1'b0, 6'd0, 1'b1}},
    '{OP_FIRST_UNHANDLED, 64'd0, 4'd0, 1'b1,
      '{STAT_UNHANDLED, 64'd0, 1'b0, 1'b0, 6'd0, 1'b1}},
    '{OP_LAST_UNHANDLED, ALL_ONES, 4'd15, 1'b1,
      '{STAT_UNHANDLED, 64'd0, 1'b0, 1'b0, 6'd0, 1'b1}},
    '{OP_PUSH,   ALL_ONES, 4'd0, 1'b1, '{STAT_OK, ALL_ONES, 1'b1, 1'b0, 6'd1, 1'b1}},
    '{OP_AND,    64'd0, 4'd0,  1'b1, '{STAT_UNDERFLOW, ALL_ONES, 1'b1, 1'b0, 6'd1, 1'b1}},
    '{OP_PUSH,   SIGN_BIT, 4'd0, 1'b1, '{STAT_OK, SIGN_BIT, 1'b1, 1'b0, 6'd2, 1'b1}},
    '{OP_RETURN, 64'd0, 4'd15, 1'b1, '{STAT_UNDERFLOW, SIGN_BIT, 1'b1, 1'b0, 6'd2, 1'b1}},
    '{OP_ROT,    64'd0, 4'd0,  1'b1, '{STAT_UNDERFLOW, SIGN_BIT, 1'b1, 1'b0, 6'd2, 1'b1}},
    '{OP_PUSH,   64'd64, 4'd0, 1'b1, '{STAT_OK, 64'd64, 1'b1, 1'b0, 6'd3, 1'b1}},
    '{OP_ROT,    64'd0, 4'd0,  1'b0, '0},
    '{OP_SWAP,   64'd0, 4'd0,  1'b0, '0},
    '{OP_DUP,    64'd0, 4'd0,  1'b0, '0},
    '{OP_RETURN, 64'd0, 4'd4,  1'b0, '0},
    '{OP_LT,     64'd0, 4'd0,  1'b0, '0},
    '{OP_SHL,    64'd0, 4'd0,  1'b0, '0},
    '{OP_SHR,    64'd0, 4'd0,  1'b0, '0},
    '{OP_PUSH,   MAX_POS, 4'd0, 1'b0, '0},
    '{OP_MINUS,  64'd0, 4'd0,  1'b0, '0},
    '{OP_DUP,    64'd0, 4'd0,  1'b0, '0},
    '{OP_MUL,    64'd0, 4'd0,  1'b0, '0},
    '{OP_PUSH,   64'd31, 4'd0, 1'b0, '0},
    '{OP_LE,     64'd0, 4'd0,  1'b0, '0},
    '{OP_XOR,    64'd0, 4'd0,  1'b1, '{STAT_UNDERFLOW, 64'd1, 1'b1, 1'b0, 6'd1, 1'b1}},
    '{OP_BRA,    64'd0, 4'd0,  1'b0, '0},
    '{OP_CLEAR,  64'd0, 4'd0,  1'b1, '{STAT_OK, 64'd0, 1'b0, 1'b0, 6'd0, 1'b1}},
    '{OP_PLUS,   64'd0, 4'd0,  1'b1, '{STAT_UNDERFLOW, 64'd0, 1'b0, 1'b0, 6'd0, 1'b1}},
    '{OP_OR,     64'd0, 4'd0,  1'b1, '{STAT_UNDERFLOW, 64'd0, 1'b0, 1'b0, 6'd0, 1'b1}},
    '{OP_EQ,     64'd0, 4'd0,  1'b1, '{STAT_UNDERFLOW, 64'd0, 1'b0, 1'b0, 6'd0, 1'b1}},
    '{OP_GT,     64'd0, 4'd0,  1'b1, '{STAT_UNDERFLOW, 64'd0, 1'b0, 1'b0, 6'd0, 1'b1}},
    '{OP_NE,     64'd0, 4'd0,  1'b1, '{STAT_UNDERFLOW, 64'd0, 1'b0, 1'b0, 6'd0, 1'b1}},
    '{OP_DUP,    64'd0, 4'd0,  1'b1, '{STAT_UNDERFLOW, 64'd0, 1'b0, 1'b0, 6'd0, 1'b1}}
  };

  dwarf_expression_stack_machine_unit #(
    .NUM_CELLS   (NUM_CELLS),
    .MAX_RETURNS (MAX_RETURNS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .return_count_i (return_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .value_valid_o  (value_valid_o),
    .branch_taken_o (branch_taken_o),
    .stack_count_o  (stack_count_o),
    .last_o         (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               due_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shadow stack machine
  // ---------------------------------------------------------------------------
  function automatic void add_result(status_e st, logic vv, logic [DATA_W-1:0] v,
                                     logic tk, logic lst);
    stack_result_t res;
    res.status = st;
    res.value  = vv ? v : '0;
    res.vvalid = vv;
    res.taken  = tk;
    res.cnt    = CNT_OUT_W'(stack_used);
    res.last   = lst;
    step_out.push_back(res);
  endfunction

  // one result describing the current top of stack
  function automatic void add_top(status_e st, logic tk);
    if (stack_used > 0) add_result(st, 1'b1, stack_vals[stack_used-1], tk, 1'b1);
    else add_result(st, 1'b0, '0, tk, 1'b1);
  endfunction

  function automatic void run_stack_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] pv,
                                       logic [RC_W-1:0] rc);
    logic [DATA_W-1:0] a, b, r;
    int n, lim, nret;
    n = stack_used;
    lim = (depth_limit_q > NUM_CELLS) ? NUM_CELLS : int'(depth_limit_q);
    step_out.delete();
    case (op)
      OP_PUSH, OP_DUP: begin
        if (op == OP_DUP && n < 1) add_top(STAT_UNDERFLOW, 1'b0);
        else if (n >= lim) add_top(STAT_OVERFLOW, 1'b0);
        else begin
          if (op == OP_PUSH) stack_vals[n] = pv;
          else stack_vals[n] = stack_vals[n-1];
          stack_used = n + 1;
          add_top(STAT_OK, 1'b0);
        end
      end
      OP_DROP, OP_BRA: begin
        if (n < 1) add_top(STAT_UNDERFLOW, 1'b0);
        else begin
          stack_used = n - 1;
          add_top(STAT_OK, (op == OP_BRA) && (stack_vals[n-1] != '0));
        end
      end
      OP_SWAP: begin
        if (n < 2) add_top(STAT_UNDERFLOW, 1'b0);
        else begin
          a = stack_vals[n-1];
          stack_vals[n-1] = stack_vals[n-2];
          stack_vals[n-2] = a;
          add_top(STAT_OK, 1'b0);
        end
      end
      // top moves to third place
      OP_ROT: begin
        if (n < 3) add_top(STAT_UNDERFLOW, 1'b0);
        else begin
          a = stack_vals[n-1];
          stack_vals[n-1] = stack_vals[n-2];
          stack_vals[n-2] = stack_vals[n-3];
          stack_vals[n-3] = a;
          add_top(STAT_OK, 1'b0);
        end
      end
      // second entry is the left operand
      OP_AND, OP_MINUS, OP_MUL, OP_OR, OP_PLUS, OP_SHL, OP_SHR, OP_XOR,
      OP_EQ, OP_GE, OP_GT, OP_LE, OP_LT, OP_NE: begin
        if (n < 2) add_top(STAT_UNDERFLOW, 1'b0);
        else begin
          b = stack_vals[n-1];
          a = stack_vals[n-2];
          case (op)
            OP_AND:   r = a & b;
            OP_MINUS: r = a - b;
            OP_MUL:   r = a * b;
            OP_OR:    r = a | b;
            OP_PLUS:  r = a + b;
            OP_SHL:   r = (b >= DATA_W) ? '0 : a << b[5:0];
            OP_SHR:   r = (b >= DATA_W) ? '0 : a >> b[5:0];
            OP_XOR:   r = a ^ b;
            OP_EQ:    r = ($signed(a) == $signed(b)) ? 64'd1 : 64'd0;
            OP_GE:    r = ($signed(a) >= $signed(b)) ? 64'd1 : 64'd0;
            OP_GT:    r = ($signed(a) >  $signed(b)) ? 64'd1 : 64'd0;
            OP_LE:    r = ($signed(a) <= $signed(b)) ? 64'd1 : 64'd0;
            OP_LT:    r = ($signed(a) <  $signed(b)) ? 64'd1 : 64'd0;
            default:  r = ($signed(a) != $signed(b)) ? 64'd1 : 64'd0;
          endcase
          stack_vals[n-2] = r;
          stack_used = n - 1;
          add_top(STAT_OK, 1'b0);
        end
      end
      // top first, stack untouched
      OP_RETURN: begin
        nret = (rc > MAX_RETURNS) ? MAX_RETURNS : int'(rc);
        if (nret > n) add_top(STAT_UNDERFLOW, 1'b0);
        else if (nret == 0) add_result(STAT_OK, 1'b0, '0, 1'b0, 1'b1);
        else begin
          for (int k = 0; k < nret; k++)
            add_result(STAT_OK, 1'b1, stack_vals[n-1-k], 1'b0, k + 1 == nret);
        end
      end
      OP_CLEAR: begin
        stack_used = 0;
        add_top(STAT_OK, 1'b0);
      end
      default: add_top(STAT_UNHANDLED, 1'b0);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic offer_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] pv,
                          logic [RC_W-1:0] rc, logic typed, stack_result_t want);
    int gap;
    if (n_ops % BURST_SPAN == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    push_value_i   <= pv;
    return_count_i <= rc;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // transfer done at this edge
    n_ops++;
    run_stack_op(op, pv, rc);
    if (typed) due_results.push_back(want);
    else foreach (step_out[k]) due_results.push_back(step_out[k]);
  endtask

  function automatic logic [OP_W-1:0] pick_op(int push_pct);
    logic [OP_W-1:0] op;
    int r;
    if ($urandom_range(0, 99) < push_pct) return OP_PUSH;
    r = $urandom_range(0, 99);
    if (r < 8) op = OP_DUP;
    else if (r < 14) op = OP_DROP;
    else if (r < 20) op = OP_SWAP;
    else if (r < 26) op = OP_ROT;
    else if (r < 62) begin
      // binary and compare ops, skipping bra
      op = OP_AND + OP_W'($urandom_range(0, 13));
      if (op >= OP_BRA) op = op + 1'b1;
    end
    else if (r < 69) op = OP_BRA;
    else if (r < 83) op = OP_RETURN;
    else if (r < 85) op = OP_CLEAR;
    else if (r < 92) op = OP_W'($urandom_range(OP_FIRST_UNHANDLED, OP_LAST_UNHANDLED));
    else op = OP_W'($urandom_range(0, 2**OP_W - 1));
    return op;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = DATA_W'($urandom_range(0, 31));            // literal
      1: v = DATA_W'($urandom_range(0, 70));            // around shift range
      2: case ($urandom_range(0, 3))
           0: v = '0;
           1: v = ALL_ONES;
           2: v = SIGN_BIT;
           default: v = MAX_POS;
         endcase
      3: v = -DATA_W'($urandom_range(1, 5));            // small negative
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // mostly counts the stack can serve, sometimes anything
  function automatic logic [RC_W-1:0] pick_count();
    int hi;
    if ($urandom_range(0, 3) == 0) return RC_W'($urandom_range(0, 2**RC_W - 1));
    hi = (stack_used < MAX_RETURNS) ? stack_used : MAX_RETURNS;
    if (hi < 1) hi = 1;
    return RC_W'($urandom_range(1, hi));
  endfunction

  task automatic run_random_ops(int n_items, int push_pct);
    for (int i = 0; i < n_items; i++)
      offer_op(pick_op(push_pct), pick_value(), pick_count(), 1'b0, '0);
  endtask

  // wait until every due result has come back, then let the block settle
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (IDLE_GUARD) @(posedge clk_i);
  endtask

  task automatic set_depth_limit(logic [LIMIT_W-1:0] lim);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    depth_limit_q = lim;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    stack_result_t got, want;
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (n_results % BURST_SPAN == 0) recv_burst = ($urandom_range(0, 3) == 0);
      gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (n_results == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.status = status_e'(status_o);
      got.value  = result_value_o;
      got.vvalid = value_valid_o;
      got.taken  = branch_taken_o;
      got.cnt    = stack_count_o;
      got.last   = last_o;
      n_results++;
      case (got.status)
        STAT_OVERFLOW:  n_overflow++;
        STAT_UNDERFLOW: n_underflow++;
        STAT_UNHANDLED: n_unhandled++;
        default: ;
      endcase
      if (got.taken) n_taken++;
      if (due_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: result %0d with nothing due: st=%0d val=%h vv=%b tk=%b cnt=%0d last=%b",
                   $realtime, n_results, got.status, got.value, got.vvalid, got.taken,
                   got.cnt, got.last);
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS) begin
            $display("%0t: result %0d mismatch", $realtime, n_results);
            $display("  exp st=%0d val=%h vv=%b tk=%b cnt=%0d last=%b", want.status,
                     want.value, want.vvalid, want.taken, want.cnt, want.last);
            $display("  got st=%0d val=%h vv=%b tk=%b cnt=%0d last=%b", got.status,
                     got.value, got.vvalid, got.taken, got.cnt, got.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : op_source
    stack_used    = 0;
    depth_limit_q = LIMIT_RESET;
    foreach (stack_vals[i]) stack_vals[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_op(directed_rows[i].op, directed_rows[i].pv, directed_rows[i].rc,
               directed_rows[i].typed, directed_rows[i].want);

    // reset limit, then push-heavy to reach a full stack
    run_random_ops(120, 30);
    run_random_ops(80, 65);

    // limit below the current depth
    settle_idle();
    set_depth_limit(LIMIT_MIN);
    run_random_ops(50, 30);

    settle_idle();
    set_depth_limit(LIMIT_ZERO);
    run_random_ops(30, 30);

    // above the physical depth
    settle_idle();
    set_depth_limit(LIMIT_MAX);
    run_random_ops(120, 40);

    settle_idle();
    mid_limit = LIMIT_W'($urandom_range(2, NUM_CELLS - 1));
    set_depth_limit(mid_limit);
    run_random_ops(100, 35);

    settle_idle();
    $display("Covered %0d ops and %0d result transfers with depth limits 32, 1, 0, 63, %0d",
             n_ops, n_results, mid_limit);
    $display("Faults: %0d overflow, %0d underflow, %0d unhandled; %0d branches taken",
             n_overflow, n_underflow, n_unhandled, n_taken);
    if (n_errors == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never seen", n_errors, due_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dsm_pkg.sv
sv/dsm_cell.sv
sv/dsm_mul.sv
sv/dwarf_expression_stack_machine_unit.sv
verif/dwarf_expression_stack_machine_unit_tb.sv
